// File: hw/rtl/rbst_pkg.sv
`default_nettype none
package rbst_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  // Quotient bits resolved by the divider stages; larger quotients saturate.
  localparam int QuoBits  = CoordW - 1;
  // Divider stages: one setup stage, one stage per quotient bit, one output stage.
  localparam int DivLat   = QuoBits + 2;
  localparam int NumAxes  = 3;
  localparam int IdxW     = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [CoordW-1:0] mag_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef enum logic [IdxW-1:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_HIGH_X = 3'd3,
    REG_HIGH_Y = 3'd4,
    REG_HIGH_Z = 3'd5
  } reg_idx_e;

  // Operands of one slab quotient.
  typedef struct packed {
    mag_t num;
    mag_t den;
    logic neg;
  } div_in_t;

endpackage
`default_nettype wire

// File: hw/rtl/ray_box_slab_test.sv
// Ray against axis-aligned box, slab method, signed Q16.16.
// Throughput: one ray per cycle; busy_o stays low, since the receiver cannot stall.
// The depth is set by the six bit-per-stage dividers plus input and
// three reduction stages. Reset clears the box registers and all stage valids.
`default_nettype none
module ray_box_slab_test import rbst_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  output logic             busy_o,
  input  wire  [CoordW-1:0] origin_x_i,
  input  wire  [CoordW-1:0] origin_y_i,
  input  wire  [CoordW-1:0] origin_z_i,
  input  wire  [CoordW-1:0] dir_x_i,
  input  wire  [CoordW-1:0] dir_y_i,
  input  wire  [CoordW-1:0] dir_z_i,
  input  wire  [CoordW-1:0] length_limit_i,
  input  wire              cfg_we_i,
  input  wire  [IdxW-1:0]  cfg_idx_i,
  input  wire  [CoordW-1:0] cfg_wdata_i,
  output logic             valid_o,
  output logic             hit_o
);

  localparam int Latency = DivLat + 3;

  // Box registers. The two bounds of an axis may come in either order.
  coord_t low_q [NumAxes];
  coord_t high_q [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        low_q[a]  <= '0;
        high_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_LOW_X:  low_q[0]  <= cfg_wdata_i;
        REG_LOW_Y:  low_q[1]  <= cfg_wdata_i;
        REG_LOW_Z:  low_q[2]  <= cfg_wdata_i;
        REG_HIGH_X: high_q[0] <= cfg_wdata_i;
        REG_HIGH_Y: high_q[1] <= cfg_wdata_i;
        REG_HIGH_Z: high_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a new ray is taken every cycle.
  assign busy_o = 1'b0;

  logic   accept;
  coord_t org [NumAxes];
  coord_t dir [NumAxes];
  assign accept = start_i && !busy_o;
  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  // Stage 0: operand magnitudes and signs for the six quotients, plus the
  // range check of axes whose direction component is zero.
  div_in_t            lo_op_q [NumAxes];
  div_in_t            hi_op_q [NumAxes];
  logic [NumAxes-1:0] dz_q;
  logic               miss_q;
  coord_t             limit_q;
  logic               vld0_q;

  logic [NumAxes-1:0] dz_d;
  logic [NumAxes-1:0] out_d;
  div_in_t            lo_op_d [NumAxes];
  div_in_t            hi_op_d [NumAxes];

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    logic signed [CoordW:0] dlo, dhi, dext;
    logic                   dneg;
    coord_t                 mn, mx;
    mag_t                   dmag;
    assign dlo  = {low_q[a][CoordW-1], low_q[a]} - {org[a][CoordW-1], org[a]};
    assign dhi  = {high_q[a][CoordW-1], high_q[a]} - {org[a][CoordW-1], org[a]};
    assign dext = {dir[a][CoordW-1], dir[a]};
    assign dneg = dir[a][CoordW-1];
    assign dmag = dneg ? CoordW'(-dext) : dir[a];
    assign mn   = (low_q[a] < high_q[a]) ? low_q[a] : high_q[a];
    assign mx   = (low_q[a] < high_q[a]) ? high_q[a] : low_q[a];
    assign dz_d[a]  = (dir[a] == '0);
    assign out_d[a] = dz_d[a] && (org[a] < mn || org[a] > mx);
    assign lo_op_d[a] = '{num: dlo[CoordW] ? CoordW'(-dlo) : dlo[CoordW-1:0],
                          den: dmag, neg: dlo[CoordW] ^ dneg};
    assign hi_op_d[a] = '{num: dhi[CoordW] ? CoordW'(-dhi) : dhi[CoordW-1:0],
                          den: dmag, neg: dhi[CoordW] ^ dneg};
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NumAxes; a++) begin
      lo_op_q[a] <= lo_op_d[a];
      hi_op_q[a] <= hi_op_d[a];
    end
    dz_q    <= dz_d;
    // An all-zero direction misses, as does an origin outside a flat slab.
    miss_q  <= (|out_d) || (&dz_d);
    limit_q <= length_limit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= accept;
    end
  end

  // Six dividers run side by side; their latency is fixed.
  coord_t t_lo [NumAxes];
  coord_t t_hi [NumAxes];
  for (genvar a = 0; a < NumAxes; a++) begin : g_div
    rbst_div u_div_lo (.clk_i(clk_i), .op_i(lo_op_q[a]), .t_o(t_lo[a]));
    rbst_div u_div_hi (.clk_i(clk_i), .op_i(hi_op_q[a]), .t_o(t_hi[a]));
  end

  // Side information travels alongside the dividers.
  logic [NumAxes-1:0] dz_dly_q    [DivLat];
  logic               miss_dly_q  [DivLat];
  coord_t             limit_dly_q [DivLat];
  logic [DivLat-1:0]  vld_dly_q;

  always_ff @(posedge clk_i) begin
    dz_dly_q[0]    <= dz_q;
    miss_dly_q[0]  <= miss_q;
    limit_dly_q[0] <= limit_q;
    for (int k = 1; k < DivLat; k++) begin
      dz_dly_q[k]    <= dz_dly_q[k-1];
      miss_dly_q[k]  <= miss_dly_q[k-1];
      limit_dly_q[k] <= limit_dly_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_dly_q <= '0;
    end else begin
      vld_dly_q <= {vld_dly_q[DivLat-2:0], vld0_q};
    end
  end

  // Stage P1: near and far value per axis. A flat axis gets neutral values,
  // which leave the later maximum and minimum unchanged.
  coord_t near_q [NumAxes];
  coord_t far_q  [NumAxes];
  logic   miss1_q, vld1_q;
  coord_t limit1_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NumAxes; a++) begin
      if (dz_dly_q[DivLat-1][a]) begin
        near_q[a] <= CoordMin;
        far_q[a]  <= CoordMax;
      end else if (t_lo[a] < t_hi[a]) begin
        near_q[a] <= t_lo[a];
        far_q[a]  <= t_hi[a];
      end else begin
        near_q[a] <= t_hi[a];
        far_q[a]  <= t_lo[a];
      end
    end
    miss1_q  <= miss_dly_q[DivLat-1];
    limit1_q <= limit_dly_q[DivLat-1];
  end

  // Stage P2: tmin is the largest near value, tmax the smallest far value.
  coord_t tmin01, tmax01;
  coord_t tmin_q, tmax_q, limit2_q;
  logic   miss2_q, vld2_q;

  assign tmin01 = (near_q[0] > near_q[1]) ? near_q[0] : near_q[1];
  assign tmax01 = (far_q[0] < far_q[1]) ? far_q[0] : far_q[1];

  always_ff @(posedge clk_i) begin
    tmin_q   <= (tmin01 > near_q[2]) ? tmin01 : near_q[2];
    tmax_q   <= (tmax01 < far_q[2]) ? tmax01 : far_q[2];
    miss2_q  <= miss1_q;
    limit2_q <= limit1_q;
  end

  // Stage P3: optional clamp to [0, length_limit] and the final compare.
  coord_t tmin_c, tmax_c;
  logic   hit_d;
  assign tmin_c = tmin_q[CoordW-1] ? '0 : tmin_q;
  assign tmax_c = (limit2_q < tmax_q) ? limit2_q : tmax_q;

  always_comb begin
    if (miss2_q) begin
      hit_d = 1'b0;
    end else if (limit2_q[CoordW-1]) begin
      hit_d = (tmin_q <= tmax_q) && !tmin_q[CoordW-1];
    end else begin
      hit_d = tmin_c <= tmax_c;
    end
  end

  logic hit_q, vld3_q;
  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_dly_q[DivLat-1];
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  assign valid_o = vld3_q;
  assign hit_o   = hit_q;

  // The strobe rises once the start transfer has passed vld0_q, vld_dly_q and
  // vld1_q to vld3_q, and is sampled at the edge after that.

  // A result strobe always traces back to a start transfer a fixed time before.
  a_strobe_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, Latency + 1))
    else $error("result strobe without a matching start transfer");

  // A start transfer always yields its result strobe after the fixed latency.
  a_start_gives_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(Latency + 1) valid_o)
    else $error("start transfer produced no result strobe");

  // A ray with no direction at all never hits.
  a_zero_dir_misses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && dir_x_i == '0 && dir_y_i == '0 && dir_z_i == '0)
      |-> ##(Latency + 1) (valid_o && !hit_o))
    else $error("zero direction ray reported a hit");

endmodule
`default_nettype wire

// File: hw/rtl/rbst_div.sv
`default_nettype none
module rbst_div import rbst_pkg::*; (
  input  wire     clk_i,
  input  div_in_t op_i,
  output coord_t  t_o
);

  localparam int DvdW = CoordW + FracBits;

  logic [DvdW-1:0]     dvd;
  logic [CoordW-1:0]   rem_q [QuoBits+1];
  logic [QuoBits-1:0]  quo_q [QuoBits+1];
  logic [QuoBits-1:0]  dvd_q [QuoBits+1];
  mag_t                den_q [QuoBits+1];
  logic                neg_q [QuoBits+1];
  logic                ovf_q [QuoBits+1];
  coord_t              t_q;

  assign dvd = {op_i.num, {FracBits{1'b0}}};

  // Setup: a quotient of 2^(CoordW-1) or more always saturates.
  always_ff @(posedge clk_i) begin
    ovf_q[0] <= (2*CoordW-1)'(dvd) >= (2*CoordW-1)'({op_i.den, {QuoBits{1'b0}}});
    rem_q[0] <= CoordW'(dvd >> QuoBits);
    dvd_q[0] <= dvd[QuoBits-1:0];
    quo_q[0] <= '0;
    den_q[0] <= op_i.den;
    neg_q[0] <= op_i.neg;
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QuoBits; k++) begin : g_step
    logic [CoordW:0] sh;
    logic            ge;
    assign sh = {rem_q[k], dvd_q[k][QuoBits-1-k]};
    assign ge = sh >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? CoordW'(sh - {1'b0, den_q[k]}) : sh[CoordW-1:0];
      quo_q[k+1] <= {quo_q[k][QuoBits-2:0], ge};
      dvd_q[k+1] <= dvd_q[k];
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (neg_q[QuoBits]) begin
      t_q <= ovf_q[QuoBits] ? CoordMin : -coord_t'({1'b0, quo_q[QuoBits]});
    end else begin
      t_q <= ovf_q[QuoBits] ? CoordMax : coord_t'({1'b0, quo_q[QuoBits]});
    end
  end

  assign t_o = t_q;

endmodule
`default_nettype wire
